### design/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IMQ_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define IMQ_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

### design/imq_pkg.sv
package imq_pkg;

  localparam int OPCODE_WIDTH = 3;
  localparam int ID_WIDTH     = 6;
  localparam int SCORE_WIDTH  = 32;
  localparam int STATUS_WIDTH = 3;

  // Operation codes.
  localparam logic [OPCODE_WIDTH-1:0] OP_INSERT = 3'd0;
  localparam logic [OPCODE_WIDTH-1:0] OP_FIND   = 3'd1;
  localparam logic [OPCODE_WIDTH-1:0] OP_ADD    = 3'd2;
  localparam logic [OPCODE_WIDTH-1:0] OP_SUB    = 3'd3;
  localparam logic [OPCODE_WIDTH-1:0] OP_REMOVE = 3'd4;
  localparam logic [OPCODE_WIDTH-1:0] OP_CROWN  = 3'd5;
  localparam logic [OPCODE_WIDTH-1:0] OP_LOCATE = 3'd6;

  // Status codes.
  localparam logic [STATUS_WIDTH-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_ABSENT  = 3'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_PRESENT = 3'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY   = 3'd4;

  // One heap slot.
  typedef struct packed {
    logic [ID_WIDTH-1:0]           id;
    logic signed [SCORE_WIDTH-1:0] score;
  } heap_entry_t;

  localparam int ENTRY_WIDTH = ID_WIDTH + SCORE_WIDTH;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POS_RD,
    S_POS_DAT,
    S_SLOT_DAT,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_LEFT,
    S_DN_CMP,
    S_PLACE,
    S_RM_RD,
    S_RM_TOP,
    S_RM_LAST,
    S_DONE
  } seq_state_t;

endpackage

### design/imq_item_if.sv
interface imq_item_if;
  import imq_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [OPCODE_WIDTH-1:0]       opcode;
  logic [ID_WIDTH-1:0]           entry_id;
  logic signed [SCORE_WIDTH-1:0] amount;

  modport source (output valid, output opcode, output entry_id, output amount, input ready);
  modport sink (input valid, input opcode, input entry_id, input amount, output ready);
endinterface

### design/imq_result_if.sv
interface imq_result_if;
  import imq_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [STATUS_WIDTH-1:0]       status;
  logic [ID_WIDTH-1:0]           result_id;
  logic signed [SCORE_WIDTH-1:0] result_score;
  logic [ID_WIDTH-1:0]           heap_position;

  modport source (output valid, output status, output result_id, output result_score,
                  output heap_position, input ready);
  modport sink (input valid, input status, input result_id, input result_score,
                input heap_position, output ready);
endinterface

### design/imq_ram.sv
module imq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### design/indexed_min_priority_queue_top.sv
// Each beat is decoded, then an error or an empty heap goes straight to the result; find and
// locate read the id-to-slot table and then the slot; insert climbs from the new last slot;
// add and subtract climb and then descend; remove minimum moves the last entry to the root and
// descends; crown repeats the removal once per entry, so it takes far longer on a full heap.
// Throughput: one beat at a time; the next beat is accepted the cycle after the result is taken.
// Reset (rst, synchronous) empties the heap and marks every id absent.
module indexed_min_priority_queue_top #(
  parameter int ID_SPACE = 64
) (
  input logic         clk,
  input logic         rst,
  imq_item_if.sink    item_in,
  imq_result_if.source result_out
);
  import imq_pkg::*;

  localparam int AW       = $clog2(ID_SPACE);
  localparam int PT_DEPTH = 2 ** ID_WIDTH;

  seq_state_t state, state_next;

  logic [OPCODE_WIDTH-1:0]       op;
  logic [ID_WIDTH-1:0]           id;
  logic signed [SCORE_WIDTH-1:0] amt;
  logic [AW-1:0]                 p;
  logic [AW-1:0]                 count;
  heap_entry_t                   cur;
  heap_entry_t                   left_e;
  logic [PT_DEPTH-1:0]           valid;
  logic [STATUS_WIDTH-1:0]       res_status;
  logic [ID_WIDTH-1:0]           res_id;
  logic signed [SCORE_WIDTH-1:0] res_score;
  logic [ID_WIDTH-1:0]           res_pos;

  logic          h_we;
  logic [AW-1:0] h_addr;
  heap_entry_t   h_wdata;
  heap_entry_t   h_rdata;
  logic                p_we;
  logic [ID_WIDTH-1:0] p_addr;
  logic [AW-1:0]       p_wdata;
  logic [AW-1:0]       p_rdata;

  // Heap slots and the id-to-slot table.
  imq_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(ID_SPACE)) u_heap_ram (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
  );

  imq_ram #(.WIDTH(AW), .DEPTH(PT_DEPTH)) u_pos_ram (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
  );

  // Decode helpers.
  logic in_range, is_full, is_addsub, is_crown;
  assign in_range  = (32'(id) < ID_SPACE);
  assign is_full   = (count >= AW'(ID_SPACE - 1));
  assign is_addsub = (op == OP_ADD) || (op == OP_SUB);
  assign is_crown  = (op == OP_CROWN);

  // Child addresses of the hole.
  logic [AW:0]   p2, p2r, cnt_x;
  logic          has_left, has_right, take_right, move_down;
  heap_entry_t   child;
  logic [AW-1:0] child_a;
  assign p2        = {p, 1'b0};
  assign p2r       = {p, 1'b1};
  assign cnt_x     = {1'b0, count};
  assign has_left  = (p2 <= cnt_x);
  assign has_right = (p2r <= cnt_x);
  assign take_right = has_right && (h_rdata.score < left_e.score);
  assign child     = take_right ? h_rdata : left_e;
  assign child_a   = take_right ? p2r[AW-1:0] : p2[AW-1:0];
  assign move_down = (child.score < cur.score);

  // Saturating add or subtract on the stored score.
  logic signed [SCORE_WIDTH:0]   sum;
  logic signed [SCORE_WIDTH-1:0] sat;
  always_comb begin
    if (op == OP_ADD) begin
      sum = {h_rdata.score[SCORE_WIDTH-1], h_rdata.score} + {amt[SCORE_WIDTH-1], amt};
    end else begin
      sum = {h_rdata.score[SCORE_WIDTH-1], h_rdata.score} - {amt[SCORE_WIDTH-1], amt};
    end
    if (sum[SCORE_WIDTH] != sum[SCORE_WIDTH-1]) begin
      sat = sum[SCORE_WIDTH] ? {1'b1, {(SCORE_WIDTH-1){1'b0}}}
                             : {1'b0, {(SCORE_WIDTH-1){1'b1}}};
    end else begin
      sat = sum[SCORE_WIDTH-1:0];
    end
  end

  logic up_move;
  assign up_move = (cur.score < h_rdata.score);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_in.valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (op) inside
          OP_INSERT: begin
            state_next = (!in_range || is_full || valid[id]) ? S_DONE : S_UP_RD;
          end
          OP_FIND, OP_LOCATE, OP_ADD, OP_SUB: begin
            state_next = (!in_range || !valid[id]) ? S_DONE : S_POS_RD;
          end
          OP_REMOVE, OP_CROWN: begin
            state_next = (count == '0) ? S_DONE : S_RM_RD;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_POS_RD:   state_next = S_POS_DAT;
      S_POS_DAT:  state_next = S_SLOT_DAT;
      S_SLOT_DAT: state_next = is_addsub ? S_UP_RD : S_DONE;
      S_UP_RD: begin
        if (p == AW'(1)) state_next = is_addsub ? S_DN_RD : S_PLACE;
        else state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (up_move) state_next = S_UP_RD;
        else state_next = is_addsub ? S_DN_RD : S_PLACE;
      end
      S_DN_RD:   state_next = has_left ? S_DN_LEFT : S_PLACE;
      S_DN_LEFT: state_next = S_DN_CMP;
      S_DN_CMP:  state_next = move_down ? S_DN_RD : S_PLACE;
      S_PLACE:   state_next = (is_crown && count != '0) ? S_RM_RD : S_DONE;
      S_RM_RD:   state_next = S_RM_TOP;
      S_RM_TOP: begin
        if (count == AW'(1)) state_next = S_DONE;
        else state_next = S_RM_LAST;
      end
      S_RM_LAST: state_next = S_DN_RD;
      S_DONE: begin
        if (result_out.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory ports and handshakes.
  always_comb begin
    h_we    = 1'b0;
    h_addr  = '0;
    h_wdata = cur;
    p_we    = 1'b0;
    p_addr  = id;
    p_wdata = p;
    unique case (state)
      S_POS_DAT: h_addr = p_rdata;
      S_UP_RD:   h_addr = p >> 1;
      S_UP_CMP: begin
        if (up_move) begin
          h_we    = 1'b1;
          h_addr  = p;
          h_wdata = h_rdata;
          p_we    = 1'b1;
          p_addr  = h_rdata.id;
        end
      end
      S_DN_RD:   h_addr = p2[AW-1:0];
      S_DN_LEFT: h_addr = p2r[AW-1:0];
      S_DN_CMP: begin
        if (move_down) begin
          h_we    = 1'b1;
          h_addr  = p;
          h_wdata = child;
          p_we    = 1'b1;
          p_addr  = child.id;
        end
      end
      S_PLACE: begin
        h_we   = 1'b1;
        h_addr = p;
        p_we   = 1'b1;
        p_addr = cur.id;
      end
      S_RM_RD:  h_addr = AW'(1);
      S_RM_TOP: h_addr = count;
      default: ;
    endcase
  end

  assign item_in.ready            = (state == S_IDLE);
  assign result_out.valid         = (state == S_DONE);
  assign result_out.status        = res_status;
  assign result_out.result_id     = res_id;
  assign result_out.result_score  = res_score;
  assign result_out.heap_position = res_pos;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      valid <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_DECODE: begin
          if (op == OP_INSERT && in_range && !is_full && !valid[id]) count <= count + AW'(1);
        end
        S_PLACE: valid[cur.id] <= 1'b1;
        S_RM_TOP: begin
          valid[h_rdata.id] <= 1'b0;
          if (count == AW'(1)) count <= '0;
        end
        S_RM_LAST: count <= count - AW'(1);
        default: ;
      endcase
    end
  end

  // Working registers and result fields.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op  <= item_in.opcode;
        id  <= item_in.entry_id;
        amt <= item_in.amount;
      end
      S_DECODE: begin
        res_status <= ST_OK;
        res_id     <= '0;
        res_score  <= '0;
        res_pos    <= '0;
        unique case (op) inside
          OP_INSERT: begin
            res_id <= id;
            if (!in_range) res_status <= ST_ABSENT;
            else if (is_full) res_status <= ST_FULL;
            else if (valid[id]) res_status <= ST_PRESENT;
            p   <= count + AW'(1);
            cur <= '{id: id, score: amt};
          end
          OP_FIND, OP_LOCATE, OP_ADD, OP_SUB: begin
            res_id <= id;
            if (!in_range || !valid[id]) res_status <= ST_ABSENT;
          end
          OP_REMOVE, OP_CROWN: begin
            if (count == '0) res_status <= ST_EMPTY;
          end
          default: ;
        endcase
      end
      S_POS_DAT: p <= p_rdata;
      S_SLOT_DAT: begin
        if (is_addsub) begin
          cur <= '{id: id, score: sat};
        end else begin
          res_score <= h_rdata.score;
          res_pos   <= ID_WIDTH'(p);
        end
      end
      S_UP_CMP: begin
        if (up_move) p <= p >> 1;
      end
      S_DN_LEFT: left_e <= h_rdata;
      S_DN_CMP: begin
        if (move_down) p <= child_a;
      end
      S_PLACE: begin
        if (!is_crown && op != OP_REMOVE) begin
          res_score <= cur.score;
          res_pos   <= ID_WIDTH'(p);
        end
      end
      S_RM_TOP: begin
        res_id    <= h_rdata.id;
        res_score <= h_rdata.score;
      end
      S_RM_LAST: begin
        cur <= h_rdata;
        p   <= AW'(1);
      end
      default: ;
    endcase
  end

endmodule

### design/imq_checker.sv
module imq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic [imq_pkg::STATUS_WIDTH-1:0] status,
  input logic [imq_pkg::SCORE_WIDTH-1:0]  result_score,
  input logic [imq_pkg::ID_WIDTH-1:0]     heap_position
);
  import imq_pkg::*;
`include "assert_macros.svh"

  // Status codes stay within the defined set.
  `IMQ_ASSERT_IMPLY(a_status_range, clk, rst, out_valid, status <= ST_EMPTY)
  // A failed operation reports no score and no slot.
  `IMQ_ASSERT_IMPLY(a_fail_zero, clk, rst, out_valid && status != ST_OK, result_score == '0 && heap_position == '0)
  // The block takes no new beat while a result is pending.
  `IMQ_ASSERT_IMPLY(a_one_at_a_time, clk, rst, out_valid, !in_ready)
  // A result never appears in the cycle after a beat is taken.
  `IMQ_ASSERT_NEXT(a_no_instant_result, clk, rst, in_valid && in_ready, !out_valid)

endmodule

bind indexed_min_priority_queue_top imq_checker u_imq_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(item_in.valid),
  .in_ready(item_in.ready),
  .out_valid(result_out.valid),
  .status(result_out.status),
  .result_score(result_out.result_score),
  .heap_position(result_out.heap_position)
);
